// ===== sv/fbpa_pkg.sv =====
// Shared types and constants of the fixed block pool allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package fbpa_pkg;

	// Pool geometry.
	localparam int MAX_BLOCKS = 256;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int ALIGNMENT  = 8;

	// Field and register widths.
	localparam int ADDR_W     = 24;
	localparam int CAP_W      = 9;
	localparam int STRIDE_W   = 17;
	localparam int OFF_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = STRIDE_W;

	// The effective stride may round up beyond the register width.
	localparam int SE_W       = STRIDE_W + 1;
	localparam int MIN_STRIDE = 8;

	// Lowest-free search: one group of flags per cycle.
	localparam int GROUP_W    = 32;
	localparam int GROUPS     = MAX_BLOCKS / GROUP_W;
	localparam int GSEL_W     = $clog2(GROUPS);
	localparam int POS_W      = $clog2(GROUP_W);

	// Restoring divider: one quotient bit per cycle.
	localparam int QUO_W      = IDX_W + 1;
	localparam int BIT_W      = $clog2(QUO_W);

	// Reset values of the configuration registers.
	localparam int CAP_RESET    = 256;
	localparam int STRIDE_RESET = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_FREE,
		OP_CLEAR,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		RS_OK,
		RS_FULL,
		RS_INVALID,
		RS_ALREADY_FREE
	} res_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DIV,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic start;
		logic scan;
		logic div;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  kind;
		logic need_scan;
		logic need_div;
		logic scan_done;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

// ===== sv/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator. An input transfer is accepted in the idle state only; a result
// is registered after the decode step for allocations by hint or on a full pool, clears,
// unknown operations and frees below the offset or far beyond the pool, after the lowest-free
// search over up to 8 groups of 32 flags for other allocations, and after the restoring
// divider, producing one of 9 quotient bits per cycle, for other frees; no new item is taken
// before the last is committed. Reset is immediate: flags, count and hint clear at once and the
// configuration returns to capacity 256, stride 16, offset 0; there is no clearing pass.
module fixed_block_pool_allocator import fbpa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            kind,
	input  logic [ADDR_W-1:0]     address,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [ADDR_W-1:0]     result_address,
	output logic [CNT_W-1:0]      used_count
);

	cmd_t  cmd;
	stat_t stat;

	// Sequencer.
	fbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	// Pool state, search, divider and output register.
	fbpa_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.address        (address),
		.cmd            (cmd),
		.stat           (stat),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.status         (status),
		.result_address (result_address),
		.used_count     (used_count)
	);

endmodule

// ===== sv/fbpa_ctrl.sv =====
// Sequencing state machine of the fixed block pool allocator.
// Depends on fbpa_pkg; drives the datapath through cmd_t and reads stat_t.
module fbpa_ctrl import fbpa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output cmd_t  cmd,
	input  stat_t stat
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.start = 1'b1;
				if (stat.need_scan) begin
					state_d = S_SCAN;
				end else if (stat.need_div) begin
					state_d = S_DIV;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (stat.div_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// Wait until the output register can take the result.
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Only a free runs the divider, only an allocation runs the search.
	a_div_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (stat.kind == OP_FREE))
		else $error("divider running for an operation other than free");

	a_scan_is_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (stat.kind == OP_ALLOC))
		else $error("flag search running for an operation other than allocate");

endmodule

// ===== sv/fbpa_datapath.sv =====
// Datapath of the fixed block pool allocator: configuration, busy flags,
// lowest-free search, address divider and output register. Depends on fbpa_pkg.
module fbpa_datapath import fbpa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [1:0]            kind,
	input  logic [ADDR_W-1:0]     address,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [1:0]            status,
	output logic [ADDR_W-1:0]     result_address,
	output logic [CNT_W-1:0]      used_count
);

	// Configuration registers.
	logic [CAP_W-1:0]    cap_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [OFF_W-1:0]    off_q;

	// Pool state.
	logic [MAX_BLOCKS-1:0] busy_q;
	logic [CNT_W-1:0]      used_q;
	logic [IDX_W-1:0]      hint_q;
	logic                  hint_valid_q;

	// Captured operation and working registers.
	op_t               kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic              found_q;
	logic              use_hint_q;
	logic [IDX_W-1:0]  idx_q;
	logic [GSEL_W-1:0] group_q;
	logic [BIT_W-1:0]  bit_q;
	logic [ADDR_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic              bad_q;

	// Output register.
	logic              out_valid_q;
	res_status_t       status_q;
	logic [ADDR_W-1:0] res_q;
	logic [CNT_W-1:0]  count_q;

	// Effective configuration.
	logic [CNT_W-1:0] cap_eff;
	logic [SE_W-1:0]  stride_min;
	logic [SE_W-1:0]  stride_eff;

	localparam logic [SE_W-1:0] ALIGN_ADD  = SE_W'(ALIGNMENT - 1);
	localparam logic [SE_W-1:0] ALIGN_MASK = ~ALIGN_ADD;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_q > CAP_W'(MAX_BLOCKS)) begin
			cap_eff = CNT_W'(MAX_BLOCKS);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
		if (stride_q < STRIDE_W'(MIN_STRIDE)) begin
			stride_min = SE_W'(MIN_STRIDE);
		end else begin
			stride_min = {1'b0, stride_q};
		end
		stride_eff = (stride_min + ALIGN_ADD) & ALIGN_MASK;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_W'(CAP_RESET);
			stride_q <= STRIDE_W'(STRIDE_RESET);
			off_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAPACITY: cap_q    <= cfg_data[CAP_W-1:0];
				CFG_STRIDE:   stride_q <= cfg_data[STRIDE_W-1:0];
				CFG_OFFSET:   off_q    <= cfg_data[OFF_W-1:0];
				default:      ;
			endcase
		end
	end

	// Decode checks on the captured operation.
	logic [ADDR_W:0]      rel_c;
	logic                 under_c;
	logic                 over_c;
	logic                 full_c;
	logic                 hint_ok_c;
	logic                 take_hint_c;

	assign rel_c       = {1'b0, addr_q} - (ADDR_W + 1)'(off_q);
	assign under_c     = rel_c[ADDR_W];
	// A quotient that needs more than QUO_W bits is out of range anyway.
	assign over_c      = (SE_W + QUO_W)'(rel_c[ADDR_W-1:0]) >= {stride_eff, {QUO_W{1'b0}}};
	assign full_c      = used_q >= cap_eff;
	assign hint_ok_c   = hint_valid_q && ({1'b0, hint_q} < cap_eff) && !busy_q[hint_q];
	assign take_hint_c = (kind_q == OP_ALLOC) && !full_c && hint_ok_c;

	// Lowest free flag in the current group, below the capacity.
	logic [GROUP_W-1:0] grp_flags;
	logic [GROUP_W-1:0] free_vec;
	logic               any_free;
	logic [POS_W-1:0]   low_pos;

	assign grp_flags = busy_q[{group_q, {POS_W{1'b0}}} +: GROUP_W];

	always_comb begin
		for (int j = 0; j < GROUP_W; j++) begin
			free_vec[j] = !grp_flags[j] && ({1'b0, group_q, POS_W'(j)} < cap_eff);
		end
		low_pos = '0;
		for (int j = GROUP_W - 1; j >= 0; j--) begin
			if (free_vec[j]) begin
				low_pos = POS_W'(j);
			end
		end
	end

	assign any_free = |free_vec;

	// One restoring division step.
	logic [SE_W+QUO_W-1:0] shifted_c;
	logic                  sub_ok_c;

	assign shifted_c = (SE_W + QUO_W)'(stride_eff) << bit_q;
	assign sub_ok_c  = (SE_W + QUO_W)'(rem_q) >= shifted_c;

	// Working registers: capture, decode, search and divide.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= OP_NONE;
			found_q    <= 1'b0;
			use_hint_q <= 1'b0;
			group_q    <= '0;
			bit_q      <= '0;
			bad_q      <= 1'b0;
		end else begin
			if (cmd.load) begin
				kind_q <= op_t'(kind);
			end
			if (cmd.start) begin
				found_q    <= take_hint_c;
				use_hint_q <= take_hint_c;
				group_q    <= '0;
				bit_q      <= BIT_W'(QUO_W - 1);
				bad_q      <= under_c || over_c;
			end
			if (cmd.scan) begin
				if (any_free) begin
					found_q <= 1'b1;
				end
				group_q <= group_q + GSEL_W'(1);
			end
			if (cmd.div) begin
				bit_q <= bit_q - BIT_W'(1);
			end
		end
	end

	// Payload side of the working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= address;
		end
		if (cmd.start) begin
			idx_q <= hint_q;
			rem_q <= rel_c[ADDR_W-1:0];
			quo_q <= '0;
		end
		if (cmd.scan && any_free) begin
			idx_q <= {group_q, low_pos};
		end
		if (cmd.div && sub_ok_c) begin
			rem_q        <= rem_q - shifted_c[ADDR_W-1:0];
			quo_q[bit_q] <= 1'b1;
		end
	end

	// Outcome of the operation.
	logic [IDX_W+SE_W-1:0] prod_c;
	logic [IDX_W+SE_W-1:0] payload_c;
	logic                  quo_ok_c;
	logic                  free_ok_c;
	res_status_t           stat_c;
	logic [ADDR_W-1:0]     res_c;
	logic [CNT_W-1:0]      used_c;

	assign prod_c    = (IDX_W + SE_W)'(idx_q) * (IDX_W + SE_W)'(stride_eff);
	assign payload_c = prod_c + (IDX_W + SE_W)'(off_q);
	assign quo_ok_c  = (rem_q == '0) && (quo_q < cap_eff);

	always_comb begin
		stat_c    = RS_OK;
		res_c     = '0;
		used_c    = used_q;
		free_ok_c = 1'b0;
		case (kind_q)
			OP_ALLOC: begin
				if (found_q) begin
					used_c = used_q + CNT_W'(1);
					res_c  = payload_c[ADDR_W-1:0];
				end else begin
					stat_c = RS_FULL;
				end
			end
			OP_FREE: begin
				if (bad_q || !quo_ok_c) begin
					stat_c = RS_INVALID;
				end else if (!busy_q[quo_q[IDX_W-1:0]]) begin
					stat_c = RS_ALREADY_FREE;
				end else begin
					free_ok_c = 1'b1;
					if (used_q != '0) begin
						used_c = used_q - CNT_W'(1);
					end
				end
			end
			OP_CLEAR: begin
				used_c = '0;
			end
			default: ;
		endcase
	end

	// Pool state update when the result is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= '0;
			used_q       <= '0;
			hint_q       <= '0;
			hint_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			used_q <= used_c;
			case (kind_q)
				OP_ALLOC: begin
					if (found_q) begin
						busy_q[idx_q] <= 1'b1;
						if (use_hint_q) begin
							hint_valid_q <= 1'b0;
						end
					end
				end
				OP_FREE: begin
					if (free_ok_c) begin
						busy_q[quo_q[IDX_W-1:0]] <= 1'b0;
						hint_q                   <= quo_q[IDX_W-1:0];
						hint_valid_q             <= 1'b1;
					end
				end
				OP_CLEAR: begin
					busy_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Output register: a held result does not block acceptance of the next operation, only its commit.
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= stat_c;
			res_q    <= res_c;
			count_q  <= used_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_address = res_q;
	assign used_count     = count_q;

	// Status to the controller.
	always_comb begin
		stat.kind      = kind_q;
		stat.need_scan = (kind_q == OP_ALLOC) && !full_c && !hint_ok_c;
		stat.need_div  = (kind_q == OP_FREE) && !under_c && !over_c;
		stat.scan_done = any_free || (group_q == GSEL_W'(GROUPS - 1));
		stat.div_done  = bit_q == '0;
		stat.out_free  = out_free;
	end

	// The used count always matches the number of busy flags.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		used_q == CNT_W'($countones(busy_q)))
		else $error("used count differs from number of busy flags");

	// A valid hint always names a free block.
	a_hint_free: assert property (@(posedge clk) disable iff (!arst_n)
		hint_valid_q |-> !busy_q[hint_q])
		else $error("hint names a busy block");

	// A result is only committed into a free output register.
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> out_free)
		else $error("result committed over an unread result");

endmodule
